// ----- rtl/core/stq_pkg.sv -----
// stq_pkg: item types, request kinds and status codes of the sorted timer queue
// no dependencies; used by sorted_timer_queue and tb_sorted_timer_queue
package stq_pkg;

    localparam int DL_W  = 32;
    localparam int TOK_W = 16;

    // request kinds
    localparam logic [1:0] KIND_ARM     = 2'd0;
    localparam logic [1:0] KIND_CANCEL  = 2'd1;
    localparam logic [1:0] KIND_PROCESS = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_FULL       = 2'd1;
    localparam logic [1:0] STATUS_BAD_CANCEL = 2'd2;

    // input item
    typedef struct packed {
        logic [1:0]       kind;
        logic [DL_W-1:0]  now;
        logic [DL_W-1:0]  delay;
        logic [TOK_W-1:0] token;
        logic [3:0]       handle;
    } t_stq_in;

    // result item
    typedef struct packed {
        logic [1:0]       status;
        logic             fired;
        logic [3:0]       slot;
        logic [TOK_W-1:0] fired_token;
        logic [DL_W-1:0]  next_deadline;
    } t_stq_out;

    // one entry of the timer memory
    typedef struct packed {
        logic [TOK_W-1:0] token;
        logic [DL_W-1:0]  deadline;
    } t_stq_timer;

endpackage

// ----- rtl/core/stq_ram.sv -----
// stq_ram: simple dual-port synchronous memory, one write and one registered read port
// no package dependencies
module stq_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/sorted_timer_queue.sv -----
// sorted_timer_queue: table of pending timers kept in deadline order, one result per request
// depends on stq_pkg and stq_ram (timer memory and order-list memory)
//
// Holds up to SLOTS timers: a timer memory with deadline and token per slot, and an
// order-list memory with the slot numbers in deadline order (ties keep arrival order).
// One request is worked on at a time; o_in_stall is high during reset and from acceptance
// until the result has been placed in the output register, which may still wait while the
// next item is taken. An arm first scans the busy bits for the lowest free slot, then
// compares list entries from the tail (the later-deadline entries plus the one the walk
// stops at), with two dependent memory reads per entry; cancel and a firing process run a
// compaction pass over the list, followed by a refresh of the earliest deadline when the
// earliest timer changes and timers remain; other requests go straight to the result. A
// held output register stalls the result. No clearing pass is needed after reset.
module sorted_timer_queue #(
    parameter int SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  stq_pkg::t_stq_in  i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output stq_pkg::t_stq_out o_out_item
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int TW = $bits(stq_pkg::t_stq_timer);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FREE,
        S_WALK_ORD,
        S_WALK_DL,
        S_WALK_CMP,
        S_INSERT,
        S_FIRE_TOK,
        S_REM_RD,
        S_REM_CHK,
        S_REM_END,
        S_HEAD_ORD,
        S_HEAD_DL,
        S_HEAD_CAP,
        S_FINAL,
        S_DONE
    } t_state;

    // control registers
    t_state                   r_state, n_state;
    logic [CW-1:0]            r_live, n_live;
    logic [SLOTS-1:0]         r_busy, n_busy;
    logic                     r_out_valid, n_out_valid;

    // working registers
    stq_pkg::t_stq_in         r_req, n_req;
    logic [stq_pkg::DL_W-1:0] r_dl, n_dl;
    logic [CW-1:0]            r_i, n_i;
    logic [SW-1:0]            r_slot, n_slot;
    logic [SW-1:0]            r_cand, n_cand;
    logic                     r_found, n_found;
    logic                     r_head_chg, n_head_chg;
    logic [stq_pkg::DL_W-1:0] r_head_dl, n_head_dl;
    logic [SW-1:0]            r_head_slot, n_head_slot;
    stq_pkg::t_stq_out        r_res, n_res;
    stq_pkg::t_stq_out        r_out, n_out;

    // memory ports
    logic                     ord_we;
    logic [SW-1:0]            ord_waddr, ord_wdata, ord_raddr, ord_rdata;
    logic                     tim_we;
    logic [SW-1:0]            tim_waddr, tim_raddr;
    stq_pkg::t_stq_timer      tim_wdata, tim_rdata;

    logic [stq_pkg::DL_W:0]   sum;
    logic [stq_pkg::DL_W-1:0] sat_dl;
    logic [stq_pkg::DL_W-1:0] head_next;
    logic [CW-1:0]            i_inc, i_dec;

    stq_ram #(.W(SW), .D(SLOTS)) u_order (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

    stq_ram #(.W(TW), .D(SLOTS)) u_timer (
        .i_clk   (i_clk),
        .i_we    (tim_we),
        .i_waddr (tim_waddr),
        .i_wdata (tim_wdata),
        .i_raddr (tim_raddr),
        .o_rdata (tim_rdata)
    );

    // saturating deadline and head of list
    assign sum       = {1'b0, i_in_item.now} + {1'b0, i_in_item.delay};
    assign sat_dl    = sum[stq_pkg::DL_W] ? '1 : sum[stq_pkg::DL_W-1:0];
    assign head_next = (r_live == '0) ? '0 : r_head_dl;
    assign i_inc     = r_i + CW'(1);
    assign i_dec     = r_i - CW'(1);

    assign o_in_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // sequencer next state and memory controls
    always_comb begin
        n_state     = r_state;
        n_live      = r_live;
        n_busy      = r_busy;
        n_out_valid = r_out_valid;
        n_req       = r_req;
        n_dl        = r_dl;
        n_i         = r_i;
        n_slot      = r_slot;
        n_cand      = r_cand;
        n_found     = r_found;
        n_head_chg  = r_head_chg;
        n_head_dl   = r_head_dl;
        n_head_slot = r_head_slot;
        n_res       = r_res;
        n_out       = r_out;
        ord_we      = 1'b0;
        ord_waddr   = '0;
        ord_wdata   = '0;
        ord_raddr   = '0;
        tim_we      = 1'b0;
        tim_waddr   = '0;
        tim_wdata   = '0;
        tim_raddr   = r_head_slot;

        // output register drains
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req               = i_in_item;
                    n_dl                = sat_dl;
                    n_res               = '0;
                    n_res.next_deadline = head_next;
                    n_state             = S_DONE;
                    unique case (i_in_item.kind)
                        stq_pkg::KIND_ARM: begin
                            if (r_live == CW'(SLOTS)) begin
                                n_res.status = stq_pkg::STATUS_FULL;
                            end else begin
                                n_slot  = '0;
                                n_state = S_FREE;
                            end
                        end
                        stq_pkg::KIND_CANCEL: begin
                            if (32'(i_in_item.handle) >= 32'(SLOTS) ||
                                !r_busy[SW'(i_in_item.handle)]) begin
                                n_res.status = stq_pkg::STATUS_BAD_CANCEL;
                            end else begin
                                n_slot     = SW'(i_in_item.handle);
                                n_i        = '0;
                                n_found    = 1'b0;
                                n_head_chg = 1'b0;
                                n_state    = S_REM_RD;
                            end
                        end
                        stq_pkg::KIND_PROCESS: begin
                            // timer memory is already read at the head slot
                            if (r_live != '0 && i_in_item.now >= r_head_dl) begin
                                n_res.fired = 1'b1;
                                n_res.slot  = 4'(r_head_slot);
                                n_slot      = r_head_slot;
                                n_i         = CW'(1);
                                n_found     = 1'b1;
                                n_head_chg  = 1'b1;
                                n_state     = S_FIRE_TOK;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // lowest free slot, one busy bit a cycle
            S_FREE: begin
                if (!r_busy[r_slot]) begin
                    if (r_live == '0) begin
                        n_i     = '0;
                        n_state = S_INSERT;
                    end else begin
                        n_i     = r_live - CW'(1);
                        n_state = S_WALK_ORD;
                    end
                end else begin
                    n_slot = r_slot + SW'(1);
                end
            end

            // walk from the tail, moving later deadlines up one place
            S_WALK_ORD: begin
                ord_raddr = r_i[SW-1:0];
                n_state   = S_WALK_DL;
            end

            S_WALK_DL: begin
                n_cand    = ord_rdata;
                tim_raddr = ord_rdata;
                n_state   = S_WALK_CMP;
            end

            S_WALK_CMP: begin
                if (tim_rdata.deadline > r_dl) begin
                    ord_we    = 1'b1;
                    ord_waddr = i_inc[SW-1:0];
                    ord_wdata = r_cand;
                    if (r_i == '0) begin
                        n_state = S_INSERT;
                    end else begin
                        n_i     = i_dec;
                        n_state = S_WALK_ORD;
                    end
                end else begin
                    n_i     = i_inc;
                    n_state = S_INSERT;
                end
            end

            // place the new timer at list position r_i
            S_INSERT: begin
                ord_we             = 1'b1;
                ord_waddr          = r_i[SW-1:0];
                ord_wdata          = r_slot;
                tim_we             = 1'b1;
                tim_waddr          = r_slot;
                tim_wdata.token    = r_req.token;
                tim_wdata.deadline = r_dl;
                n_busy[r_slot]     = 1'b1;
                n_live             = r_live + CW'(1);
                if (r_i == '0) begin
                    n_head_dl   = r_dl;
                    n_head_slot = r_slot;
                end
                n_state = S_FINAL;
            end

            S_FIRE_TOK: begin
                n_res.fired_token = tim_rdata.token;
                n_state           = S_REM_RD;
            end

            // compaction pass: entries after the removed one move down
            S_REM_RD: begin
                if (r_i == r_live) begin
                    n_state = S_REM_END;
                end else begin
                    ord_raddr = r_i[SW-1:0];
                    n_state   = S_REM_CHK;
                end
            end

            S_REM_CHK: begin
                if (r_found) begin
                    ord_we    = 1'b1;
                    ord_waddr = i_dec[SW-1:0];
                    ord_wdata = ord_rdata;
                end else if (ord_rdata == r_slot) begin
                    n_found = 1'b1;
                    if (r_i == '0) begin
                        n_head_chg = 1'b1;
                    end
                end
                n_i     = i_inc;
                n_state = S_REM_RD;
            end

            S_REM_END: begin
                n_live         = r_live - CW'(1);
                n_busy[r_slot] = 1'b0;
                if (r_head_chg && r_live != CW'(1)) begin
                    n_state = S_HEAD_ORD;
                end else begin
                    n_state = S_FINAL;
                end
            end

            // refresh the earliest deadline
            S_HEAD_ORD: begin
                ord_raddr = '0;
                n_state   = S_HEAD_DL;
            end

            S_HEAD_DL: begin
                n_head_slot = ord_rdata;
                tim_raddr   = ord_rdata;
                n_state     = S_HEAD_CAP;
            end

            S_HEAD_CAP: begin
                n_head_dl = tim_rdata.deadline;
                n_state   = S_FINAL;
            end

            // arm and cancel report the list after the change
            S_FINAL: begin
                if (r_req.kind != stq_pkg::KIND_PROCESS) begin
                    n_res.next_deadline = head_next;
                    if (r_req.kind == stq_pkg::KIND_ARM) begin
                        n_res.slot = 4'(r_slot);
                    end
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_live      <= '0;
            r_busy      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_live      <= n_live;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_dl        <= n_dl;
        r_i         <= n_i;
        r_slot      <= n_slot;
        r_cand      <= n_cand;
        r_found     <= n_found;
        r_head_chg  <= n_head_chg;
        r_head_dl   <= n_head_dl;
        r_head_slot <= n_head_slot;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    // busy bits and live count agree
    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_busy) == int'(r_live))
        else $error("busy slots and live count disagree");

    // between requests the cached head names a busy slot
    a_head_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_live != '0) |-> r_busy[r_head_slot])
        else $error("head slot not busy");

    // an accepted item blocks the input in the next cycle
    a_accept_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // a fired timer always comes with an ok status
    a_fire_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.fired) |-> (o_out_item.status == stq_pkg::STATUS_OK))
        else $error("fired result with bad status");

endmodule

// ----- tb/sv/tb_sorted_timer_queue.sv -----
// tb_sorted_timer_queue: self-checking bench for the sorted timer queue, with its own timer table
// predictor and random idling on both valid/stall channels
// depends on stq_pkg and sorted_timer_queue
module tb_sorted_timer_queue;

    localparam int          TIMER_SLOTS  = 16;
    localparam logic [1:0]  KIND_NONE    = 2'd3;
    localparam int          RANDOM_ITEMS = 1450;
    localparam int          HOLD_CYCLES  = 300;
    localparam int unsigned CYCLE_LIMIT  = 600000;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    stq_pkg::t_stq_in  i_in_item   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    stq_pkg::t_stq_out o_out_item;

    sorted_timer_queue #(.SLOTS(TIMER_SLOTS)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // timer table as the predictor sees it
    logic [stq_pkg::DL_W-1:0]  timer_deadline [TIMER_SLOTS];
    logic [stq_pkg::TOK_W-1:0] timer_token    [TIMER_SLOTS];
    bit                        slot_taken     [TIMER_SLOTS];
    int                        deadline_order [$];
    stq_pkg::t_stq_out         expected_results [$];

    // idling controls and run statistics
    int                       sender_gap_max   = 10;
    int                       receiver_gap_max = 10;
    int                       receiver_hold    = 0;
    logic [stq_pkg::DL_W-1:0] wall_clock       = 32'd5000;
    int                       items_sent       = 0;
    int                       results_checked  = 0;
    int                       fired_count      = 0;
    int                       full_count       = 0;
    int                       bad_cancel_count = 0;
    int                       mismatch_count   = 0;
    int unsigned              cycle_count      = 0;
    stq_pkg::t_stq_out        wanted_result;

    function automatic logic [stq_pkg::DL_W-1:0] earliest_deadline();
        if (deadline_order.size() == 0)
            return '0;
        return timer_deadline[deadline_order[0]];
    endfunction

    // one request against the predicted table, returns the result it should give
    function automatic stq_pkg::t_stq_out timer_table_step(input stq_pkg::t_stq_in req);
        stq_pkg::t_stq_out        res;
        logic [stq_pkg::DL_W:0]   sum;
        logic [stq_pkg::DL_W-1:0] due;
        int                       s;
        int                       pos;
        res = '0;
        res.next_deadline = earliest_deadline();
        case (req.kind)
            stq_pkg::KIND_ARM: begin
                if (deadline_order.size() >= TIMER_SLOTS) begin
                    res.status = stq_pkg::STATUS_FULL;
                end else begin
                    // saturating deadline
                    sum = {1'b0, req.now} + {1'b0, req.delay};
                    due = sum[stq_pkg::DL_W] ? '1 : sum[stq_pkg::DL_W-1:0];
                    s = 0;
                    while (s < TIMER_SLOTS && slot_taken[s])
                        s++;
                    // after every entry with an equal or earlier deadline
                    pos = 0;
                    while (pos < deadline_order.size() &&
                           timer_deadline[deadline_order[pos]] <= due)
                        pos++;
                    deadline_order.insert(pos, s);
                    slot_taken[s]     = 1'b1;
                    timer_deadline[s] = due;
                    timer_token[s]    = req.token;
                    res.slot          = 4'(s);
                    res.next_deadline = earliest_deadline();
                end
            end
            stq_pkg::KIND_CANCEL: begin
                if (!slot_taken[req.handle]) begin
                    res.status = stq_pkg::STATUS_BAD_CANCEL;
                end else begin
                    pos = 0;
                    while (pos < deadline_order.size() && deadline_order[pos] != req.handle)
                        pos++;
                    if (pos < deadline_order.size())
                        deadline_order.delete(pos);
                    slot_taken[req.handle] = 1'b0;
                    res.next_deadline = earliest_deadline();
                end
            end
            stq_pkg::KIND_PROCESS: begin
                // reported deadline is the one before removal
                if (deadline_order.size() != 0 && req.now >= res.next_deadline) begin
                    s = deadline_order[0];
                    res.fired       = 1'b1;
                    res.slot        = 4'(s);
                    res.fired_token = timer_token[s];
                    deadline_order.delete(0);
                    slot_taken[s] = 1'b0;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic stq_pkg::t_stq_in make_request(input logic [1:0] kind,
                                                      input logic [stq_pkg::DL_W-1:0] now,
                                                      input logic [stq_pkg::DL_W-1:0] delay,
                                                      input logic [stq_pkg::TOK_W-1:0] token,
                                                      input logic [3:0] handle);
        stq_pkg::t_stq_in req;
        req.kind   = kind;
        req.now    = now;
        req.delay  = delay;
        req.token  = token;
        req.handle = handle;
        return req;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 20)
            $display("  %s wrong on result %0d: expected %0h, got %0h",
                     what, results_checked, want, got);
    endtask

    // offer one item after a random gap, predict once it is taken
    task automatic send_request(input stq_pkg::t_stq_in req);
        int                gap;
        stq_pkg::t_stq_out predicted;
        gap = $urandom_range(0, sender_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do @(posedge i_clk); while (o_in_stall);
        predicted = timer_table_step(req);
        expected_results.push_back(predicted);
        items_sent++;
        if (predicted.fired)
            fired_count++;
        if (predicted.status == stq_pkg::STATUS_FULL)
            full_count++;
        if (predicted.status == stq_pkg::STATUS_BAD_CANCEL)
            bad_cancel_count++;
    endtask

    // stop offering and wait for every pending result
    task automatic settle_queue();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // fire everything left in the table
    task automatic drain_table();
        while (deadline_order.size() != 0)
            send_request(make_request(stq_pkg::KIND_PROCESS, '1, $urandom(),
                                      16'($urandom()), 4'($urandom())));
    endtask

    // receiver: random stall before each item, or one long hold on request
    initial begin : result_sink
        int wait_cycles;
        wait (i_rst_n);
        forever begin
            if (receiver_hold > 0) begin
                wait_cycles   = receiver_hold;
                receiver_hold = 0;
            end else begin
                wait_cycles = $urandom_range(0, receiver_gap_max);
            end
            if (wait_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unpredicted result", '0, 64'(o_out_item));
            end else begin
                wanted_result = expected_results.pop_front();
                if (o_out_item.status !== wanted_result.status)
                    report_mismatch("status", 64'(wanted_result.status),
                                    64'(o_out_item.status));
                if (o_out_item.fired !== wanted_result.fired)
                    report_mismatch("fired", 64'(wanted_result.fired), 64'(o_out_item.fired));
                if (o_out_item.slot !== wanted_result.slot)
                    report_mismatch("slot", 64'(wanted_result.slot), 64'(o_out_item.slot));
                if (o_out_item.fired_token !== wanted_result.fired_token)
                    report_mismatch("fired_token", 64'(wanted_result.fired_token),
                                    64'(o_out_item.fired_token));
                if (o_out_item.next_deadline !== wanted_result.next_deadline)
                    report_mismatch("next_deadline", 64'(wanted_result.next_deadline),
                                    64'(o_out_item.next_deadline));
            end
            results_checked++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("sorted_timer_queue: mismatch");
            $finish;
        end
    end

    // hand-picked sequence: empty table, ties, saturation, zero deadline, slot reuse
    task automatic test_directed_cases();
        send_request(make_request(stq_pkg::KIND_PROCESS, '0, $urandom(), 16'($urandom()),
                                  4'd0));
        send_request(make_request(stq_pkg::KIND_CANCEL, $urandom(), $urandom(),
                                  16'($urandom()), 4'd0));
        send_request(make_request(stq_pkg::KIND_CANCEL, $urandom(), $urandom(),
                                  16'($urandom()), 4'd15));
        send_request(make_request(KIND_NONE, $urandom(), $urandom(), 16'($urandom()),
                                  4'($urandom())));
        send_request(make_request(stq_pkg::KIND_ARM, '0, '0, '0, 4'($urandom())));
        send_request(make_request(stq_pkg::KIND_ARM, '1, '1, '1, 4'($urandom())));
        send_request(make_request(stq_pkg::KIND_ARM, 32'd1000, 32'd500, 16'h1234,
                                  4'($urandom())));
        send_request(make_request(stq_pkg::KIND_ARM, 32'd1499, 32'd1, 16'hA5A5,
                                  4'($urandom())));
        send_request(make_request(stq_pkg::KIND_ARM, '0, '1, 16'h5A5A, 4'($urandom())));
        send_request(make_request(KIND_NONE, '1, '1, '1, 4'd15));
        send_request(make_request(stq_pkg::KIND_PROCESS, '0, $urandom(), 16'($urandom()),
                                  4'd9));
        send_request(make_request(stq_pkg::KIND_PROCESS, 32'd1499, $urandom(),
                                  16'($urandom()), 4'd3));
        send_request(make_request(stq_pkg::KIND_CANCEL, $urandom(), $urandom(),
                                  16'($urandom()), 4'd2));
        send_request(make_request(stq_pkg::KIND_CANCEL, $urandom(), $urandom(),
                                  16'($urandom()), 4'd2));
        send_request(make_request(stq_pkg::KIND_ARM, 32'd10, 32'd5, 16'h7777,
                                  4'($urandom())));
        send_request(make_request(stq_pkg::KIND_PROCESS, 32'd1500, $urandom(),
                                  16'($urandom()), 4'd0));
        send_request(make_request(stq_pkg::KIND_PROCESS, 32'd1500, $urandom(),
                                  16'($urandom()), 4'd0));
        send_request(make_request(stq_pkg::KIND_PROCESS, 32'hFFFF_FFFE, '0, '0, 4'd0));
        send_request(make_request(stq_pkg::KIND_CANCEL, '0, '0, '0, 4'd4));
        send_request(make_request(stq_pkg::KIND_PROCESS, '1, '1, '1, 4'd15));
        send_request(make_request(stq_pkg::KIND_PROCESS, '1, '0, '0, 4'd0));
        send_request(make_request(stq_pkg::KIND_CANCEL, '0, '0, '0, 4'd1));
        settle_queue();
    endtask

    // fill every slot with close deadlines, overflow, free one, refill, drain
    task automatic test_full_table();
        logic [stq_pkg::DL_W-1:0] base;
        base = wall_clock;
        for (int n = 0; n < TIMER_SLOTS + 2; n++)
            send_request(make_request(stq_pkg::KIND_ARM, base, $urandom_range(0, 3),
                                      16'($urandom()), 4'($urandom())));
        send_request(make_request(KIND_NONE, base, $urandom(), 16'($urandom()), 4'd7));
        send_request(make_request(stq_pkg::KIND_CANCEL, base, $urandom(), 16'($urandom()),
                                  4'd7));
        send_request(make_request(stq_pkg::KIND_CANCEL, base, $urandom(), 16'($urandom()),
                                  4'd7));
        send_request(make_request(stq_pkg::KIND_ARM, base, 32'd1, 16'($urandom()),
                                  4'($urandom())));
        send_request(make_request(stq_pkg::KIND_ARM, base, 32'd2, 16'($urandom()),
                                  4'($urandom())));
        // gradual expiry, some checks find nothing due yet
        for (int n = 0; n < TIMER_SLOTS; n++)
            send_request(make_request(stq_pkg::KIND_PROCESS, base + n / 4, $urandom(),
                                      16'($urandom()), 4'($urandom())));
        drain_table();
        settle_queue();
    endtask

    // receiver holds off while the sender keeps offering, input side must stall
    task automatic test_output_hold();
        int roll;
        sender_gap_max = 0;
        receiver_hold  = HOLD_CYCLES;
        for (int n = 0; n < 40; n++) begin
            roll = $urandom_range(0, 9);
            wall_clock += $urandom_range(0, 8);
            if (roll < 6)
                send_request(make_request(stq_pkg::KIND_ARM, wall_clock,
                                          $urandom_range(0, 40), 16'($urandom()),
                                          4'($urandom())));
            else if (roll < 9)
                send_request(make_request(stq_pkg::KIND_PROCESS, wall_clock, $urandom(),
                                          16'($urandom()), 4'($urandom())));
            else
                send_request(make_request(KIND_NONE, wall_clock, $urandom(),
                                          16'($urandom()), 4'($urandom())));
        end
        drain_table();
        settle_queue();
        sender_gap_max = 10;
    endtask

    // random traffic in chunks with changing mix and idling
    task automatic test_random_traffic();
        stq_pkg::t_stq_in req;
        int               arm_weight;
        int               roll;
        arm_weight = 45;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                sender_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 10;
                receiver_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
                case ($urandom_range(0, 2))
                    0: arm_weight = 25;
                    1: arm_weight = 45;
                    default: arm_weight = 70;
                endcase
            end
            // clock mostly creeps forward, now and then jumps anywhere
            wall_clock += $urandom_range(0, 12);
            roll = $urandom_range(0, 99);
            if (roll < 2)
                wall_clock = $urandom();
            else if (roll == 2)
                wall_clock = 32'hFFFF_FFFF - $urandom_range(0, 100);
            req.now    = wall_clock;
            req.token  = 16'($urandom());
            req.handle = 4'($urandom());
            roll = $urandom_range(0, 99);
            if (roll < 70)
                req.delay = $urandom_range(0, 60);
            else if (roll < 80)
                req.delay = '0;
            else if (roll < 90)
                req.delay = $urandom();
            else
                req.delay = 32'hFFFF_FFFF - $urandom_range(0, 40);
            roll = $urandom_range(0, 99);
            if (roll < arm_weight) begin
                req.kind = stq_pkg::KIND_ARM;
            end else if (roll < arm_weight + 20) begin
                req.kind = stq_pkg::KIND_CANCEL;
                if ($urandom_range(0, 4) != 0 && deadline_order.size() != 0)
                    req.handle = 4'(deadline_order[$urandom_range(0, deadline_order.size() - 1)]);
            end else if (roll < 96) begin
                req.kind = stq_pkg::KIND_PROCESS;
                // hit the earliest deadline exactly now and then
                if ($urandom_range(0, 4) == 0 && deadline_order.size() != 0)
                    req.now = earliest_deadline();
            end else begin
                req.kind = KIND_NONE;
            end
            send_request(req);
        end
        settle_queue();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_full_table();
        test_output_hold();
        test_random_traffic();
        settle_queue();
        repeat (100) @(posedge i_clk);
        $display("%0d requests sent, %0d results checked in %0d cycles",
                 items_sent, results_checked, cycle_count);
        $display("%0d timers fired, %0d arms on a full table, %0d cancels of idle slots",
                 fired_count, full_count, bad_cancel_count);
        if (mismatch_count == 0)
            $display("sorted_timer_queue: match");
        else
            $display("sorted_timer_queue: mismatch");
        $finish;
    end

endmodule
